// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wtt_pkg.sv =====
// ----------------------------------------------------------------------------
// wtt_pkg
// Shared types and codes of the windowed trend tracker.
// ----------------------------------------------------------------------------
package wtt_pkg;

  localparam int ChanW   = 4;
  localparam int KindW   = 2;
  localparam int SampleW = 16;
  localparam int TrendW  = 2;
  localparam int InDataW  = 24;  // channel + sample, byte padded
  localparam int OutDataW = 24;  // channel + trend + full + value, byte padded

  // sample kinds
  localparam logic [KindW-1:0] KIND_TEMP = 2'd0;
  localparam logic [KindW-1:0] KIND_HUM  = 2'd1;
  localparam logic [KindW-1:0] KIND_BATT = 2'd2;
  localparam logic [KindW-1:0] KIND_NONE = 2'd3;

  // trend codes
  localparam logic [TrendW-1:0] TREND_BLANK = 2'd0;
  localparam logic [TrendW-1:0] TREND_UP    = 2'd1;
  localparam logic [TrendW-1:0] TREND_DOWN  = 2'd2;
  localparam logic [TrendW-1:0] TREND_SAME  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_META_RD,
    ST_META,
    ST_SUM,
    ST_MUL,
    ST_CMP,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIX,
    ST_DONE
  } wtt_state_e;

endpackage

// ===== rtl/core/windowed_trend_tracker_core.sv =====
// ----------------------------------------------------------------------------
// windowed_trend_tracker_core
// Per-channel moving-average trend detector with a serial sum and divider.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                              tuser
//  --------  ---  ----------------------------------------------  -----
//  s_axis    in   channel[3:0], sample[19:4], pad[23:20]          kind
//  m_axis    out  out_channel[3:0], trend[5:4], history_full[6],  -
//                 shown_value[22:7], pad[23]
//
//  One item at a time: ready stays low from an input transfer until the
//  result is loaded. With history held for the channel, a temperature or
//  humidity item sums the history and compares n times the sample with it; a
//  battery item sums it and shows the mean through the bit-serial restoring
//  divider. A first sample, kind three or an unknown channel skips the sum.
//  The history sum walks the history memory one entry per cycle through its
//  single read port.
//  Reset clears the state machine, the output valid and the per-channel valid
//  bits; history contents need no clearing since only filled slots are read.
//  A result waits in the output register while the next item is accepted;
//  the sequencer stalls only when a new result is ready and the old one is
//  still held.
//
module windowed_trend_tracker_core #(
  parameter int CHANNELS = 16,
  parameter int DEPTH    = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [3:0] channel, [19:4] sample, [23:20] zero
  input  logic [wtt_pkg::InDataW-1:0]      s_axis_tdata_i,
  // [1:0] kind
  input  logic [wtt_pkg::KindW-1:0]        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [3:0] out_channel, [5:4] trend, [6] history_full, [22:7] shown_value, [23] zero
  output logic [wtt_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;  // channel index
  localparam int PW   = $clog2(DEPTH);                          // history slot
  localparam int NW   = $clog2(DEPTH + 1);                      // fill count
  localparam int SW   = wtt_pkg::SampleW + NW;                  // sum / product
  localparam int CNTW = $clog2(SW);                             // divider steps
  localparam int HIST_ENTRIES = CHANNELS * (1 << PW);

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  logic signed [wtt_pkg::SampleW-1:0] hist_mem [HIST_ENTRIES];
  logic [NW-1:0]                      fill_mem [CHANNELS];
  logic [PW-1:0]                      head_mem [CHANNELS];
  logic [wtt_pkg::TrendW-1:0]         trend_mem [CHANNELS];
  logic                               full_mem [CHANNELS];
  logic [CHANNELS-1:0]                chan_vld_q;

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  wtt_pkg::wtt_state_e state_q, state_d;

  logic [wtt_pkg::ChanW-1:0]          ch_q, ch_d;
  logic [wtt_pkg::KindW-1:0]          kind_q, kind_d;
  logic signed [wtt_pkg::SampleW-1:0] smp_q, smp_d;
  logic [NW-1:0]                      n_q, n_d;
  logic [PW-1:0]                      head_q, head_d;
  logic [wtt_pkg::TrendW-1:0]         trend_q, trend_d;
  logic                               full_q, full_d;
  logic                               upd_q, upd_d;
  logic signed [wtt_pkg::SampleW-1:0] shown_q, shown_d;
  logic signed [SW-1:0]               acc_q, acc_d;     // sum, then quotient
  logic signed [SW-1:0]               prod_q, prod_d;
  logic [NW-1:0]                      idx_q, idx_d;
  logic                               pend_q, pend_d;
  logic [NW-1:0]                      rem_q, rem_d;
  logic [CNTW-1:0]                    cnt_q, cnt_d;
  logic                               neg_q, neg_d;

  logic                               out_vld_q, out_vld_d;
  logic [wtt_pkg::OutDataW-1:0]       out_data_q, out_data_d;

  // memory read data
  logic signed [wtt_pkg::SampleW-1:0] hist_rd_q;
  logic [NW-1:0]                      fill_rd_q;
  logic [PW-1:0]                      head_rd_q;
  logic [wtt_pkg::TrendW-1:0]         trend_rd_q;
  logic                               full_rd_q;
  logic                               vld_rd_q;

  // memory control
  logic              hist_re, hist_we, meta_re, meta_we;
  logic [CW+PW-1:0]  hist_raddr, hist_waddr;
  logic [CW-1:0]     ch_idx;
  logic              ch_ok;
  logic [NW-1:0]     fill_wr;
  logic [PW-1:0]     head_wr;

  // divider step
  logic [NW:0]       div_shift;
  logic              div_ge;

  assign ch_idx = CW'(ch_q);
  assign ch_ok  = (32'(ch_q) < CHANNELS);

  assign div_shift = {rem_q, acc_q[SW-1]};
  assign div_ge    = (div_shift >= {1'b0, n_q});

  assign fill_wr = full_q ? n_q : n_q + NW'(1);
  assign head_wr = !full_q ? head_q :
                   (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);

  assign hist_waddr = {ch_idx, (full_q ? head_q : n_q[PW-1:0])};
  assign hist_raddr = {ch_idx, idx_q[PW-1:0]};

  assign s_axis_tready_o = (state_q == wtt_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Next state and datapath
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    kind_d   = kind_q;
    smp_d    = smp_q;
    n_d      = n_q;
    head_d   = head_q;
    trend_d  = trend_q;
    full_d   = full_q;
    upd_d    = upd_q;
    shown_d  = shown_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    hist_re  = 1'b0;
    hist_we  = 1'b0;
    meta_re  = 1'b0;
    meta_we  = 1'b0;

    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;

    case (state_q)
      wtt_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          ch_d    = s_axis_tdata_i[wtt_pkg::ChanW-1:0];
          smp_d   = s_axis_tdata_i[wtt_pkg::ChanW +: wtt_pkg::SampleW];
          kind_d  = s_axis_tuser_i;
          state_d = wtt_pkg::ST_META_RD;
        end
      end

      wtt_pkg::ST_META_RD: begin
        meta_re = ch_ok;
        state_d = wtt_pkg::ST_META;
      end

      wtt_pkg::ST_META: begin
        shown_d = smp_q;
        acc_d   = '0;
        idx_d   = '0;
        pend_d  = 1'b0;
        if (!ch_ok) begin
          // out-of-range channel: pass the sample, blank status
          upd_d   = 1'b0;
          trend_d = wtt_pkg::TREND_BLANK;
          full_d  = 1'b0;
          state_d = wtt_pkg::ST_DONE;
        end else if (kind_q == wtt_pkg::KIND_NONE) begin
          // unused kind: report stored status, no update
          upd_d   = 1'b0;
          trend_d = vld_rd_q ? trend_rd_q : wtt_pkg::TREND_BLANK;
          full_d  = vld_rd_q && full_rd_q;
          state_d = wtt_pkg::ST_DONE;
        end else begin
          upd_d   = 1'b1;
          n_d     = vld_rd_q ? fill_rd_q : '0;
          head_d  = vld_rd_q ? head_rd_q : '0;
          trend_d = vld_rd_q ? trend_rd_q : wtt_pkg::TREND_BLANK;
          full_d  = vld_rd_q && (fill_rd_q == NW'(DEPTH));
          if (!vld_rd_q || fill_rd_q == '0) begin
            trend_d = wtt_pkg::TREND_BLANK;
            state_d = wtt_pkg::ST_DONE;
          end else begin
            state_d = wtt_pkg::ST_SUM;
          end
        end
      end

      // one history read per cycle, each added on the cycle after its read
      wtt_pkg::ST_SUM: begin
        if (pend_q) begin
          acc_d = acc_q + SW'(hist_rd_q);
        end
        if (idx_q != n_q) begin
          hist_re = 1'b1;
          idx_d   = idx_q + NW'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = (kind_q == wtt_pkg::KIND_BATT) ? wtt_pkg::ST_DIV_INIT
                                                   : wtt_pkg::ST_MUL;
        end
      end

      wtt_pkg::ST_MUL: begin
        prod_d  = SW'(smp_q) * SW'($signed({1'b0, n_q}));
        state_d = wtt_pkg::ST_CMP;
      end

      wtt_pkg::ST_CMP: begin
        if (prod_q > acc_q) begin
          trend_d = wtt_pkg::TREND_UP;
        end else if (prod_q < acc_q) begin
          trend_d = wtt_pkg::TREND_DOWN;
        end else begin
          trend_d = wtt_pkg::TREND_SAME;
        end
        state_d = wtt_pkg::ST_DONE;
      end

      // divide |sum| by n, restoring, one quotient bit per cycle
      wtt_pkg::ST_DIV_INIT: begin
        neg_d   = acc_q[SW-1];
        acc_d   = acc_q[SW-1] ? -acc_q : acc_q;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = wtt_pkg::ST_DIV;
      end

      wtt_pkg::ST_DIV: begin
        rem_d = div_ge ? NW'(div_shift - {1'b0, n_q}) : NW'(div_shift);
        acc_d = {acc_q[SW-2:0], div_ge};
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(SW - 1)) begin
          state_d = wtt_pkg::ST_DIV_FIX;
        end
      end

      wtt_pkg::ST_DIV_FIX: begin
        shown_d = neg_q ? -acc_q[wtt_pkg::SampleW-1:0] : acc_q[wtt_pkg::SampleW-1:0];
        state_d = wtt_pkg::ST_DONE;
      end

      wtt_pkg::ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          hist_we    = upd_q;
          meta_we    = upd_q;
          out_vld_d  = 1'b1;
          out_data_d = {1'b0, shown_q, full_q, trend_q, ch_q};
          state_d    = wtt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = wtt_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wtt_pkg::ST_IDLE;
      out_vld_q  <= 1'b0;
      chan_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (meta_we) begin
        chan_vld_q[ch_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    kind_q     <= kind_d;
    smp_q      <= smp_d;
    n_q        <= n_d;
    head_q     <= head_d;
    trend_q    <= trend_d;
    full_q     <= full_d;
    upd_q      <= upd_d;
    shown_q    <= shown_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    idx_q      <= idx_d;
    pend_q     <= pend_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= smp_q;
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[hist_raddr];
    end
  end

  // per-channel status memory
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      fill_mem[ch_idx]  <= fill_wr;
      head_mem[ch_idx]  <= head_wr;
      trend_mem[ch_idx] <= trend_q;
      full_mem[ch_idx]  <= full_q;
    end
    if (meta_re) begin
      fill_rd_q  <= fill_mem[ch_idx];
      head_rd_q  <= head_mem[ch_idx];
      trend_rd_q <= trend_mem[ch_idx];
      full_rd_q  <= full_mem[ch_idx];
      vld_rd_q   <= chan_vld_q[ch_idx];
    end
  end

endmodule

// ===== rtl/core/wtt_checker.sv =====
// ----------------------------------------------------------------------------
// wtt_checker
// Port-level checks of the windowed trend tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wtt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [wtt_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // result held while stalled
  `ASSERT_NEXT(a_out_vld_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result valid dropped under stall")
  `ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o), "result data changed under stall")

  // sequencer goes busy right after an input transfer
  `ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready stayed high after input transfer")

  // a new result is loaded only as the sequencer returns to idle
  `ASSERT_CLK(a_res_at_idle, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> s_axis_tready_o, "result appeared while busy")

endmodule

bind windowed_trend_tracker_core wtt_checker u_wtt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/windowed_trend_tracker_core_tb.sv =====
// ----------------------------------------------------------------------------
// windowed_trend_tracker_core_tb
// Self-checking bench: directed rows, then a long random run. Every output
// transfer is checked field by field against an in-bench channel-history
// predictor or a typed row's own result. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module windowed_trend_tracker_core_tb;

  localparam int CHANNELS       = 16;
  localparam int DEPTH          = 8;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int QUIET_TAIL     = 150;   // last items run without idling
  localparam int PRESSURE_AT    = 400;   // sender drains the block here
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int NUM_ROWS       = 24;

  typedef struct packed {
    logic [wtt_pkg::ChanW-1:0]          chan;
    logic [wtt_pkg::TrendW-1:0]         trend;
    logic                               full;
    logic signed [wtt_pkg::SampleW-1:0] value;
  } report_t;

  typedef struct {
    logic [wtt_pkg::ChanW-1:0]          chan;
    logic [wtt_pkg::KindW-1:0]          kind;
    logic signed [wtt_pkg::SampleW-1:0] smp;
    bit                                 typed;  // row carries its own expected result
    report_t                            want;
  } row_t;

  logic                           clk_i    = 1'b0;
  logic                           rst_ni   = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic [wtt_pkg::InDataW-1:0]    s_tdata  = '0;
  logic [wtt_pkg::KindW-1:0]      s_tuser  = wtt_pkg::KIND_TEMP;
  logic                           m_tready = 1'b1;
  logic                           s_tready;
  logic                           m_tvalid;
  logic [wtt_pkg::OutDataW-1:0]   m_tdata;

  // predictor state, one slot per channel
  logic signed [wtt_pkg::SampleW-1:0] hist_mem   [CHANNELS][DEPTH];
  int                                 hist_fill  [CHANNELS];
  logic [wtt_pkg::TrendW-1:0]         trend_reg  [CHANNELS];
  logic                               full_reg   [CHANNELS];

  report_t                            expected_reports[$];
  logic signed [wtt_pkg::SampleW-1:0] last_sample [CHANNELS];
  row_t                               directed_rows [NUM_ROWS];

  int  fail_count    = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  full_seen     = 0;
  int  trend_seen [4];
  int  idle_cycles   = 0;
  int  stall_left    = 0;
  bit  quiet_tail    = 1'b0;

  windowed_trend_tracker_core #(
    .CHANNELS(CHANNELS),
    .DEPTH   (DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Updates the channel history and returns the report the block should emit.
  function automatic report_t track_sample(input logic [wtt_pkg::ChanW-1:0] ch,
                                           input logic [wtt_pkg::KindW-1:0] kind,
                                           input logic signed [wtt_pkg::SampleW-1:0] smp);
    report_t r;
    longint  sum;
    longint  scaled;
    int      n;
    r.chan  = ch;
    r.trend = wtt_pkg::TREND_BLANK;
    r.full  = 1'b0;
    r.value = smp;
    if (ch < CHANNELS && kind != wtt_pkg::KIND_NONE) begin
      n   = hist_fill[ch];
      sum = 0;
      for (int i = 0; i < n; i++) sum += hist_mem[ch][i];
      if (n == 0) begin
        trend_reg[ch] = wtt_pkg::TREND_BLANK;
      end else if (kind == wtt_pkg::KIND_BATT) begin
        r.value = wtt_pkg::SampleW'(sum / n);  // truncates toward zero
      end else begin
        scaled = longint'(smp) * n;
        if (scaled > sum)      trend_reg[ch] = wtt_pkg::TREND_UP;
        else if (scaled < sum) trend_reg[ch] = wtt_pkg::TREND_DOWN;
        else                   trend_reg[ch] = wtt_pkg::TREND_SAME;
      end
      if (n == DEPTH) begin
        full_reg[ch] = 1'b1;
        for (int i = 0; i < DEPTH - 1; i++) hist_mem[ch][i] = hist_mem[ch][i+1];
        n = DEPTH - 1;
      end else begin
        full_reg[ch] = 1'b0;
      end
      hist_mem[ch][n] = smp;
      hist_fill[ch]   = n + 1;
      r.trend = trend_reg[ch];
      r.full  = full_reg[ch];
    end else if (ch < CHANNELS) begin
      // unused kind: report stored flags, touch nothing
      r.trend = trend_reg[ch];
      r.full  = full_reg[ch];
    end
    return r;
  endfunction

  // Presents one item and holds it until the transfer happens.
  task automatic send_sample(input logic [wtt_pkg::ChanW-1:0] ch,
                             input logic [wtt_pkg::KindW-1:0] kind,
                             input logic signed [wtt_pkg::SampleW-1:0] smp,
                             input bit typed, input report_t want);
    report_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, smp, ch};
    s_tuser  <= kind;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    r = track_sample(ch, kind, smp);
    expected_reports.push_back(typed ? want : r);
    last_sample[ch] = smp;
    items_sent++;
  endtask

  // Output side: check each transfer, then pick next cycle's ready.
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (m_tvalid && m_tready) begin
      got.chan  = m_tdata[3:0];
      got.trend = m_tdata[5:4];
      got.full  = m_tdata[6];
      got.value = m_tdata[22:7];
      results_seen++;
      trend_seen[got.trend]++;
      if (got.full) full_seen++;
      if (expected_reports.size() == 0) begin
        $error("result with nothing pending: out_channel %0d", got.chan);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (got.chan !== want.chan) begin
          $error("out_channel: expected %0d, actual %0d", want.chan, got.chan);
          fail_count++;
        end
        if (got.trend !== want.trend) begin
          $error("trend: expected %0d, actual %0d", want.trend, got.trend);
          fail_count++;
        end
        if (got.full !== want.full) begin
          $error("history_full: expected %0d, actual %0d", want.full, got.full);
          fail_count++;
        end
        if (got.value !== want.value) begin
          $error("shown_value: expected %0d, actual %0d", want.value, got.value);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!quiet_tail && rst_ni && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 6) - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready   <= 1'b1;
    end
  end

  // Watchdog: too long without any transfer on either side.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, expected_reports.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [wtt_pkg::ChanW-1:0]          ch;
    logic [wtt_pkg::KindW-1:0]          kind;
    logic signed [wtt_pkg::SampleW-1:0] smp;
    int                                 pick;
    report_t                            none_rep;

    none_rep = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      hist_fill[c]   = 0;
      trend_reg[c]   = wtt_pkg::TREND_BLANK;
      full_reg[c]    = 1'b0;
      last_sample[c] = '0;
      for (int d = 0; d < DEPTH; d++) hist_mem[c][d] = '0;
    end
    for (int t = 0; t < 4; t++) trend_seen[t] = 0;

    directed_rows = '{
      // unused kind straight after reset
      '{4'd0, wtt_pkg::KIND_NONE, 16'sh1234, 1'b1, '{4'd0, wtt_pkg::TREND_BLANK, 1'b0, 16'sh1234}},
      // first sample of a channel, then the opposite extreme
      '{4'd0, wtt_pkg::KIND_TEMP, 16'sh7FFF, 1'b1, '{4'd0, wtt_pkg::TREND_BLANK, 1'b0, 16'sh7FFF}},
      '{4'd0, wtt_pkg::KIND_TEMP, 16'sh8000, 1'b1, '{4'd0, wtt_pkg::TREND_DOWN, 1'b0, 16'sh8000}},
      '{4'd0, wtt_pkg::KIND_HUM,  16'sh8000, 1'b0, none_rep},
      // battery with no history shows the sample, then the earlier mean
      '{4'd1, wtt_pkg::KIND_BATT, 16'sh8000, 1'b1, '{4'd1, wtt_pkg::TREND_BLANK, 1'b0, 16'sh8000}},
      '{4'd1, wtt_pkg::KIND_BATT, 16'sh7FFF, 1'b1, '{4'd1, wtt_pkg::TREND_BLANK, 1'b0, 16'sh8000}},
      // same and up
      '{4'd2, wtt_pkg::KIND_HUM,  16'sd16,   1'b1, '{4'd2, wtt_pkg::TREND_BLANK, 1'b0, 16'sd16}},
      '{4'd2, wtt_pkg::KIND_HUM,  16'sd16,   1'b1, '{4'd2, wtt_pkg::TREND_SAME, 1'b0, 16'sd16}},
      '{4'd2, wtt_pkg::KIND_TEMP, 16'sd17,   1'b1, '{4'd2, wtt_pkg::TREND_UP, 1'b0, 16'sd17}},
      '{4'd2, wtt_pkg::KIND_NONE, -16'sd1,   1'b1, '{4'd2, wtt_pkg::TREND_UP, 1'b0, -16'sd1}},
      // fill one channel to DEPTH, then roll the oldest entry out
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd100,  1'b0, none_rep},
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd200,  1'b0, none_rep},
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd300,  1'b0, none_rep},
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd400,  1'b0, none_rep},
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd500,  1'b0, none_rep},
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd600,  1'b0, none_rep},
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd700,  1'b0, none_rep},
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd800,  1'b0, none_rep},
      '{4'd3, wtt_pkg::KIND_TEMP, 16'sd0,    1'b1, '{4'd3, wtt_pkg::TREND_DOWN, 1'b1, 16'sd0}},
      '{4'd3, wtt_pkg::KIND_BATT, 16'sd5,    1'b0, none_rep},
      // negative mean truncates toward zero
      '{4'd4, wtt_pkg::KIND_BATT, -16'sd1,   1'b0, none_rep},
      '{4'd4, wtt_pkg::KIND_BATT, 16'sd0,    1'b0, none_rep},
      '{4'd4, wtt_pkg::KIND_BATT, -16'sd2,   1'b0, none_rep},
      '{4'd15, wtt_pkg::KIND_HUM, 16'sh7FFF, 1'b1, '{4'd15, wtt_pkg::TREND_BLANK, 1'b0, 16'sh7FFF}}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].chan, directed_rows[i].kind, directed_rows[i].smp,
                  directed_rows[i].typed, directed_rows[i].want);

    // Random part: mostly a few hot channels so histories fill and roll over;
    // samples hover near the last value so every trend turns up.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;
      if (k == PRESSURE_AT) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
        while (expected_reports.size() != 0) @(posedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      ch   = ($urandom_range(0, 3) != 0) ? wtt_pkg::ChanW'($urandom_range(0, 3))
                                         : wtt_pkg::ChanW'($urandom_range(0, CHANNELS - 1));
      pick = $urandom_range(0, 19);
      if (pick < 8)       kind = wtt_pkg::KIND_TEMP;
      else if (pick < 14) kind = wtt_pkg::KIND_HUM;
      else if (pick < 19) kind = wtt_pkg::KIND_BATT;
      else                kind = wtt_pkg::KIND_NONE;
      case ($urandom_range(0, 3))
        0:       smp = wtt_pkg::SampleW'($urandom());
        1:       smp = last_sample[ch];
        default: smp = wtt_pkg::SampleW'(last_sample[ch] + $signed($urandom_range(0, 8)) - 4);
      endcase
      send_sample(ch, kind, smp, 1'b0, none_rep);
    end
    s_tvalid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples (%0d directed) over 16 channels and all kinds; %0d results.",
             items_sent, NUM_ROWS, results_seen);
    $display("Trends blank/up/down/same: %0d/%0d/%0d/%0d; %0d with history full.",
             trend_seen[0], trend_seen[1], trend_seen[2], trend_seen[3], full_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
